>>> rtl/pctl_pkg.sv
// ----------------------------------------------------------------------------
// pctl_pkg: shared types and constants of the PID controller step block
// Holds the sequencer states, the register indexes, the status record of the
// arithmetic units and the fixed constants of the time base.
// ----------------------------------------------------------------------------
`default_nettype none

package pctl_pkg;

  // Digit width of the shared multiplier; one digit of the multiplier operand per cycle.
  localparam int MUL_DIG  = 16;
  // Time base: elapsed time comes in milliseconds.
  localparam int MS_PER_S = 1000;
  localparam int MS_BITS  = 10;
  localparam int EL_BITS  = 16;

  typedef enum logic [1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_EL,
    ST_DIV_EL,
    ST_INT,
    ST_MUL_I,
    ST_MUL_K,
    ST_DIV_K,
    ST_MUL_D,
    ST_FIN
  } pctl_state_t;

  // Status of an iterative arithmetic unit; done is a one-cycle pulse.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic ld_term;
    logic add_term;
    logic upd_int;
    logic emit;
  } seq_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pid_controller_step.sv
// ----------------------------------------------------------------------------
// pid_controller_step: fixed-point PID controller, one drive value per request
// Sequencer and datapath around a shared digit-serial multiplier and a shared
// radix-4 divider.
// ----------------------------------------------------------------------------
// Each input request carries a setpoint, a measurement (signed, FRAC_BITS
// fraction bits) and the milliseconds since the previous request, and yields
// one drive value plus a flag that is set when the drive or the integral was
// clipped. Work runs one request at a time through a sequencer that reuses
// one multiplier (one 16-bit operand digit per cycle) and one divider (two
// quotient bits per cycle). A request with zero setpoint and zero elapsed
// time needs only the proportional product; the two divider passes are the
// integral increment and the derivative rate. in_tready is high only while the
// sequencer is idle; a finished result waits in the output register while the
// next request is taken. Gains must be written through the cfg port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_step #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  // in_tdata fields from bit 0: setpoint, measured, elapsed_ms, zero fill
  input  wire logic [((2*DATA_WIDTH+pctl_pkg::EL_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                                           in_tvalid,
  output logic                                                in_tready,
  // out_tdata fields from bit 0: drive, zero fill
  output logic [((DATA_WIDTH+7)/8)*8-1:0]                     out_tdata,
  // out_tuser fields from bit 0: saturated
  output logic                                                out_tuser,
  output logic                                                out_tvalid,
  input  wire logic                                           out_tready,
  input  wire logic                                           cfg_wen,
  input  wire logic [1:0]                                     cfg_index,
  input  wire logic [DATA_WIDTH-1:0]                          cfg_wdata
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int EB   = pctl_pkg::EL_BITS;
  localparam int IW   = W + F;
  localparam int EW   = W + 1;
  localparam int DW   = W + 2;
  localparam int RW   = DW + pctl_pkg::MS_BITS;
  localparam int XW   = W + ((F > RW - W) ? F : (RW - W));
  localparam int DIG  = pctl_pkg::MUL_DIG;
  localparam int NDG  = (((W > EB + 1) ? W : (EB + 1)) + DIG - 1) / DIG;
  localparam int BW   = NDG * DIG;
  localparam int PW   = XW + BW;
  localparam int SW   = PW - F + 2;
  localparam int AW   = ((IW > XW) ? IW : XW) + 1;
  localparam int MW   = ((W + EB + 1) / 2) * 2;
  localparam int ODW  = ((W + 7) / 8) * 8;

  pctl_pkg::pctl_state_t state_r;
  pctl_pkg::pctl_state_t state_nxt;
  pctl_pkg::seq_ctl_t    ctl;
  pctl_pkg::unit_sts_t   mul_sts;
  pctl_pkg::unit_sts_t   div_sts;

  logic signed [W-1:0]   gain_p_r;
  logic signed [W-1:0]   gain_i_r;
  logic signed [W-1:0]   gain_d_r;
  logic signed [IW-1:0]  integ_r;
  logic signed [IW-1:0]  integ_nxt;
  logic signed [EW-1:0]  prev_err_r;
  logic signed [EW-1:0]  err_r;
  logic signed [DW-1:0]  diff_r;
  logic [EB-1:0]         el_r;
  logic                  sp_nz_r;
  logic                  sat_r;
  logic signed [SW-1:0]  sum_r;
  logic [W-1:0]          drive_r;
  logic                  out_sat_r;
  logic                  out_valid_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  el_nz;
  logic signed [W-1:0]   sp_in;
  logic signed [W-1:0]   ms_in;
  logic signed [EW-1:0]  err_in;
  logic signed [DW-1:0]  diff_in;

  logic signed [XW-1:0]  mul_x;
  logic [BW-1:0]         mul_b;
  logic signed [PW-1:0]  mul_acc;
  logic [PW-1:0]         acc_abs;
  logic [EB-1:0]         div_dvs;
  logic signed [XW-1:0]  div_quot;
  logic signed [SW-1:0]  term;

  logic signed [AW-1:0]  int_sum;
  logic                  int_ovf;
  logic                  drv_ovf;
  logic [W-1:0]          drv_val;

  assign in_tready  = (state_r == pctl_pkg::ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign el_nz      = (el_r != '0);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'(drive_r);
  assign out_tuser  = out_sat_r;

  assign sp_in   = in_tdata[W-1:0];
  assign ms_in   = in_tdata[2*W-1:W];
  assign err_in  = EW'(sp_in) - EW'(ms_in);
  assign diff_in = DW'(err_in) - DW'(prev_err_r);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pctl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pctl_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = pctl_pkg::ST_MUL_P;
      end
      pctl_pkg::ST_MUL_P: begin
        if (mul_sts.done) begin
          if (sp_nz_r) begin
            state_nxt = el_nz ? pctl_pkg::ST_MUL_EL : pctl_pkg::ST_MUL_I;
          end else begin
            state_nxt = el_nz ? pctl_pkg::ST_MUL_K : pctl_pkg::ST_FIN;
          end
        end
      end
      pctl_pkg::ST_MUL_EL: begin
        if (mul_sts.done) state_nxt = pctl_pkg::ST_DIV_EL;
      end
      pctl_pkg::ST_DIV_EL: begin
        if (div_sts.done) state_nxt = pctl_pkg::ST_INT;
      end
      pctl_pkg::ST_INT: begin
        state_nxt = pctl_pkg::ST_MUL_I;
      end
      pctl_pkg::ST_MUL_I: begin
        if (mul_sts.done) state_nxt = el_nz ? pctl_pkg::ST_MUL_K : pctl_pkg::ST_FIN;
      end
      pctl_pkg::ST_MUL_K: begin
        if (mul_sts.done) state_nxt = pctl_pkg::ST_DIV_K;
      end
      pctl_pkg::ST_DIV_K: begin
        if (div_sts.done) state_nxt = pctl_pkg::ST_MUL_D;
      end
      pctl_pkg::ST_MUL_D: begin
        if (mul_sts.done) state_nxt = pctl_pkg::ST_FIN;
      end
      pctl_pkg::ST_FIN: begin
        if (out_free) state_nxt = pctl_pkg::ST_IDLE;
      end
      default: state_nxt = pctl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.mul_start = (state_nxt != state_r) &&
                    (state_nxt inside {pctl_pkg::ST_MUL_P, pctl_pkg::ST_MUL_EL,
                                       pctl_pkg::ST_MUL_I, pctl_pkg::ST_MUL_K,
                                       pctl_pkg::ST_MUL_D});
    ctl.div_start = (state_nxt != state_r) &&
                    (state_nxt inside {pctl_pkg::ST_DIV_EL, pctl_pkg::ST_DIV_K});
    ctl.ld_term   = (state_r == pctl_pkg::ST_MUL_P) && mul_sts.done;
    ctl.add_term  = ((state_r == pctl_pkg::ST_MUL_I) || (state_r == pctl_pkg::ST_MUL_D)) &&
                    mul_sts.done;
    ctl.upd_int   = (state_r == pctl_pkg::ST_INT);
    ctl.emit      = (state_r == pctl_pkg::ST_FIN) && out_free;
  end

  // ---------------- operand selection ----------------
  always_comb begin
    case (state_nxt)
      pctl_pkg::ST_MUL_P: begin
        mul_x = XW'(err_in);
        mul_b = BW'(gain_p_r);
      end
      pctl_pkg::ST_MUL_EL: begin
        mul_x = XW'(err_r);
        mul_b = BW'(el_r);
      end
      pctl_pkg::ST_MUL_I: begin
        mul_x = XW'(integ_nxt);
        mul_b = BW'(gain_i_r);
      end
      pctl_pkg::ST_MUL_K: begin
        mul_x = XW'(diff_r);
        mul_b = BW'(pctl_pkg::MS_PER_S);
      end
      default: begin
        mul_x = div_quot;
        mul_b = BW'(gain_d_r);
      end
    endcase
  end

  assign acc_abs = mul_acc[PW-1] ? (~mul_acc + PW'(1)) : mul_acc;
  assign div_dvs = (state_nxt == pctl_pkg::ST_DIV_EL) ? EB'(pctl_pkg::MS_PER_S) : el_r;
  // Each gain product is floored before it joins the sum.
  assign term    = SW'(mul_acc >>> F);

  pctl_mul #(
    .XW (XW),
    .BW (BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .x     (mul_x),
    .b     (mul_b),
    .acc   (mul_acc),
    .sts   (mul_sts)
  );

  pctl_div #(
    .MW (MW),
    .QW (XW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctl.div_start),
    .dvd_mag (acc_abs[MW-1:0]),
    .neg     (mul_acc[PW-1]),
    .dvs     (div_dvs),
    .quot    (div_quot),
    .sts     (div_sts)
  );

  // ---------------- integral and drive saturation ----------------
  always_comb begin
    int_sum   = AW'(integ_r) + AW'(div_quot);
    int_ovf   = ~((&int_sum[AW-1:IW-1]) | ~(|int_sum[AW-1:IW-1]));
    integ_nxt = integ_r;
    if (ctl.upd_int) begin
      if (int_ovf) begin
        integ_nxt = int_sum[AW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
        integ_nxt = int_sum[IW-1:0];
      end
    end
  end

  always_comb begin
    drv_ovf = ~((&sum_r[SW-1:W-1]) | ~(|sum_r[SW-1:W-1]));
    if (drv_ovf) begin
      drv_val = sum_r[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      drv_val = sum_r[W-1:0];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          pctl_pkg::REG_GAIN_P: gain_p_r <= cfg_wdata;
          pctl_pkg::REG_GAIN_I: gain_i_r <= cfg_wdata;
          pctl_pkg::REG_GAIN_D: gain_d_r <= cfg_wdata;
          default: ;
        endcase
      end
      integ_r <= integ_nxt;
      if (ctl.emit) begin
        prev_err_r  <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r   <= err_in;
      diff_r  <= diff_in;
      sp_nz_r <= |sp_in;
      el_r    <= in_tdata[2*W+EB-1:2*W];
      sat_r   <= 1'b0;
    end else if (ctl.upd_int && int_ovf) begin
      sat_r <= 1'b1;
    end
    if (ctl.ld_term) begin
      sum_r <= term;
    end else if (ctl.add_term) begin
      sum_r <= sum_r + term;
    end
    if (ctl.emit) begin
      drive_r   <= drv_val;
      out_sat_r <= sat_r | drv_ovf;
    end
  end

  // ---------------- assertions ----------------
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy at the same time");

  // A new product may start in the cycle in which the previous one reports done.
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mul_start |-> !mul_sts.busy)
    else $error("multiplier started while still working");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> !div_sts.busy && (div_dvs != '0))
    else $error("divider started busy or with a zero divisor");

  a_integral_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pctl_pkg::ST_IDLE) && !sp_nz_r |=> $stable(integ_r))
    else $error("integral changed for a request with zero setpoint");

endmodule

`default_nettype wire

>>> rtl/pctl_mul.sv
// ----------------------------------------------------------------------------
// pctl_mul: shared digit-serial multiplier
// Multiplies a signed operand by a signed multiplier operand, one digit of the
// multiplier per cycle, most significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module pctl_mul #(
  parameter int XW = 48,
  parameter int BW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [XW-1:0]      x,
  input  wire logic        [BW-1:0]      b,
  output logic signed      [XW+BW-1:0]   acc,
  output pctl_pkg::unit_sts_t            sts
);

  localparam int DIG = pctl_pkg::MUL_DIG;
  localparam int ND  = BW / DIG;
  localparam int PW  = XW + BW;
  localparam int CW  = $clog2(ND + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic                 first_r;
  logic signed [XW-1:0] x_r;
  logic [BW-1:0]        b_r;
  logic signed [PW-1:0] acc_r;

  logic [DIG-1:0]         top_dig;
  logic signed [DIG:0]    dg;
  logic signed [XW+DIG:0] prod;
  logic signed [PW-1:0]   acc_nxt;

  // The top digit carries the sign of the multiplier operand; the others are unsigned.
  always_comb begin
    top_dig = b_r[BW-1 -: DIG];
    dg      = first_r ? {top_dig[DIG-1], top_dig} : {1'b0, top_dig};
    prod    = x_r * dg;
    acc_nxt = (acc_r <<< DIG) + PW'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r     <= x;
      b_r     <= b;
      acc_r   <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      b_r     <= b_r << DIG;
      first_r <= 1'b0;
    end
  end

  assign acc      = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> rtl/pctl_div.sv
// ----------------------------------------------------------------------------
// pctl_div: shared radix-4 divider
// Divides an unsigned dividend magnitude by a nonzero 16-bit divisor, two
// quotient bits per cycle, then applies the sign in a final fix step. The
// quotient truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pctl_div #(
  parameter int MW = 48,
  parameter int QW = 48
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [MW-1:0]                        dvd_mag,
  input  wire logic                                 neg,
  input  wire logic [pctl_pkg::EL_BITS-1:0]         dvs,
  output logic signed [QW-1:0]                      quot,
  output pctl_pkg::unit_sts_t                       sts
);

  localparam int EB    = pctl_pkg::EL_BITS;
  localparam int STEPS = MW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic                 busy_r;
  logic                 fix_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [MW-1:0]        dq_r;
  logic [EB-1:0]        rem_r;
  logic [EB-1:0]        d_r;
  logic                 neg_r;
  logic signed [QW-1:0] quot_r;

  logic [EB:0]       dx;
  logic [EB:0]       t1;
  logic [EB:0]       t2;
  logic              q1;
  logic              q2;
  logic [EB-1:0]     r1;
  logic [EB-1:0]     r2;
  logic [QW+MW-1:0]  qext;
  logic [QW+MW-1:0]  qsgn;

  always_comb begin
    dx   = {1'b0, d_r};
    t1   = {rem_r, dq_r[MW-1]};
    q1   = (t1 >= dx);
    r1   = q1 ? EB'(t1 - dx) : t1[EB-1:0];
    t2   = {r1, dq_r[MW-2]};
    q2   = (t2 >= dx);
    r2   = q2 ? EB'(t2 - dx) : t2[EB-1:0];
    qext = (QW + MW)'(dq_r);
    qsgn = neg_r ? (~qext + (QW + MW)'(1)) : qext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dvd_mag;
      rem_r <= '0;
      d_r   <= dvs;
      neg_r <= neg;
    end else if (busy_r) begin
      dq_r  <= {dq_r[MW-3:0], q1, q2};
      rem_r <= r2;
    end
    if (fix_r) begin
      quot_r <= qsgn[QW-1:0];
    end
  end

  assign quot     = quot_r;
  assign sts.busy = busy_r | fix_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire
